// ----- src/salc_pkg.sv -----
// ----------------------------------------------------------------------------
// salc_pkg
// Shared constants, payload types and state encoding for the cache tag and
// LRU controller.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int MAX_SETS_LOG = 8;
    localparam int MAX_WAYS     = 8;
    localparam int ADDRESS_BITS = 32;

    localparam int NUM_SETS = 1 << MAX_SETS_LOG;
    localparam int SET_W    = (MAX_SETS_LOG > 0) ? MAX_SETS_LOG : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int FILL_W   = $clog2(MAX_WAYS + 1);
    localparam int TAG_W    = 30;
    localparam int AGE_W    = 3;
    localparam int COST_W   = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 4;

    localparam logic [COST_W-1:0] MEM_COST = COST_W'(100);
    localparam logic [COST_W-1:0] HIT_COST = COST_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_SETS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_BLOCK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WR_ALLOC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WR_BACK    = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [31:0] address;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic              wrote_back;
        logic [COST_W-1:0] cost_cycles;
    } t_out_item;

    typedef struct packed {
        logic [MAX_WAYS-1:0][TAG_W-1:0] tags;
        logic [MAX_WAYS-1:0][AGE_W-1:0] ages;
        logic [MAX_WAYS-1:0]            dirty;
        logic [FILL_W-1:0]              fill;
    } t_row;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPD
    } t_state;

endpackage

// ----- src/set_assoc_cache_lru_tag_controller_top.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tag_controller_top
// Tag and true-LRU controller for a set-associative cache.
// ----------------------------------------------------------------------------
// Each access passes through the capture, lookup and update states. The set's
// row (tags, ages, dirty marks, fill count) is read from the single-port row
// memory at the transfer edge. The next cycle compares tags and picks the
// victim. Then, once the result register is free, the update state writes the
// updated row back and loads the result register. A new access is taken once
// the row write is done, so an access is not taken before the last one is
// through. A result that is not taken holds the row write, and with it the
// next access, until it is taken. Rows are marked valid by flip-flops cleared
// at reset, so no clearing pass is needed. Configuration writes are always
// taken; the user must make them only while no access is in flight, and the
// block itself does not enforce this.
module set_assoc_cache_lru_tag_controller_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [salc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [salc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  salc_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output salc_pkg::t_out_item           o_out_data
);
    import salc_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    salc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    salc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- src/salc_ctrl.sv -----
// ----------------------------------------------------------------------------
// salc_ctrl
// Sequencer: capture and set read, tag lookup, then row update and result.
// ----------------------------------------------------------------------------
module salc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  salc_pkg::t_status i_status,
    output salc_pkg::t_cmd    o_cmd
);
    import salc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                if (!i_status.out_busy) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- src/salc_datapath.sv -----
// ----------------------------------------------------------------------------
// salc_datapath
// Configuration registers, set row memory, tag compare, LRU update and
// result register.
// ----------------------------------------------------------------------------
module salc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [salc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [salc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  salc_pkg::t_in_item            i_in_data,
    input  salc_pkg::t_cmd                i_cmd,
    output salc_pkg::t_status             o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output salc_pkg::t_out_item           o_out_data
);
    import salc_pkg::*;

    logic [3:0] r_log2_sets, r_log2_block, r_ways;
    logic       r_wr_alloc, r_wr_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_sets  <= 4'd0;
            r_log2_block <= 4'd4;
            r_ways       <= 4'd1;
            r_wr_alloc   <= 1'b1;
            r_wr_back    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOG2_SETS:  r_log2_sets  <= i_cfg_data;
                CFG_LOG2_BLOCK: r_log2_block <= i_cfg_data;
                CFG_WAYS:       r_ways       <= i_cfg_data;
                CFG_WR_ALLOC:   r_wr_alloc   <= i_cfg_data[0];
                CFG_WR_BACK:    r_wr_back    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped configuration
    logic [3:0]        ls, lb;
    logic [FILL_W-1:0] nw;
    always_comb begin
        ls = (r_log2_sets > 4'(MAX_SETS_LOG)) ? 4'(MAX_SETS_LOG) : r_log2_sets;
        lb = (r_log2_block < 4'd2) ? 4'd2 : ((r_log2_block > 4'd12) ? 4'd12 : r_log2_block);
        if (r_ways < 4'd1) begin
            nw = FILL_W'(1);
        end else if (r_ways > 4'(MAX_WAYS)) begin
            nw = FILL_W'(MAX_WAYS);
        end else begin
            nw = FILL_W'(r_ways);
        end
    end

    // address split
    logic [31:0]      addr;
    logic [31:0]      set_full;
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag_in;
    always_comb begin
        addr     = 32'(i_in_data.address[ADDRESS_BITS-1:0]);
        set_full = (addr >> lb) & ((32'd1 << ls) - 32'd1);
        set_idx  = set_full[SET_W-1:0];
        tag_in   = TAG_W'(addr >> (5'(lb) + 5'(ls)));
    end

    logic             r_store;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_store <= i_in_data.req_type;
            r_set   <= set_idx;
            r_tag   <= tag_in;
        end
    end

    // set row memory with per-row valid flags
    t_row                mem [NUM_SETS];
    logic [NUM_SETS-1:0] r_row_vld;
    t_row                r_rd_row;
    logic                r_rd_vld;
    t_row                n_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_row <= mem[set_idx];
        end
        if (i_cmd.update) begin
            mem[r_set] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_rd_vld <= r_row_vld[set_idx];
            end
            if (i_cmd.update) begin
                r_row_vld[r_set] <= 1'b1;
            end
        end
    end

    t_row row;
    always_comb begin
        row = r_rd_row;
        if (!r_rd_vld) begin
            row.ages  = '0;
            row.dirty = '0;
            row.fill  = '0;
        end
    end

    // lookup
    logic [FILL_W-1:0] f;
    logic              hit_c;
    logic [WAY_W-1:0]  hway_c, vway_c;
    logic [AGE_W-1:0]  best;
    always_comb begin
        f      = (row.fill > nw) ? nw : row.fill;
        hit_c  = 1'b0;
        hway_c = '0;
        vway_c = '0;
        best   = row.ages[0];
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (FILL_W'(w) < f && !hit_c && row.tags[w] == r_tag) begin
                hit_c  = 1'b1;
                hway_c = WAY_W'(w);
            end
            if (w > 0 && FILL_W'(w) < f && row.ages[w] > best) begin
                best   = row.ages[w];
                vway_c = WAY_W'(w);
            end
        end
    end

    logic              r_hit;
    logic [WAY_W-1:0]  r_hway, r_vway;
    logic [FILL_W-1:0] r_f;
    t_row              r_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit  <= hit_c;
            r_hway <= hway_c;
            r_vway <= vway_c;
            r_f    <= f;
            r_row  <= row;
        end
    end

    // update
    logic [COST_W-1:0] miss_cost, cost;
    logic              alloc, wb;
    logic [WAY_W-1:0]  way;
    logic [AGE_W-1:0]  a, top;
    always_comb begin
        n_row     = r_row;
        miss_cost = MEM_COST << (lb - 4'd2);
        alloc     = !r_store || r_wr_back || r_wr_alloc;
        wb        = 1'b0;
        top       = AGE_W'(nw - FILL_W'(1));
        way       = r_hway;
        a         = r_row.ages[r_hway];
        if (r_hit) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (FILL_W'(w) < r_f && r_row.ages[w] < a) begin
                    n_row.ages[w] = r_row.ages[w] + AGE_W'(1);
                end
            end
            n_row.ages[way] = '0;
            if (r_store && r_wr_back) begin
                n_row.dirty[way] = 1'b1;
            end
        end else if (alloc) begin
            if (r_f < nw) begin
                way        = WAY_W'(r_f);
                n_row.fill = r_f + FILL_W'(1);
            end else begin
                way = r_vway;
                wb  = r_wr_back && r_row.dirty[r_vway];
            end
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (FILL_W'(w) < r_f && r_row.ages[w] < top) begin
                    n_row.ages[w] = r_row.ages[w] + AGE_W'(1);
                end
            end
            n_row.tags[way]  = r_tag;
            n_row.ages[way]  = '0;
            n_row.dirty[way] = r_store && r_wr_back;
        end

        if (!r_store || r_wr_back) begin
            cost = r_hit ? HIT_COST : miss_cost;
        end else if (r_wr_alloc) begin
            cost = r_hit ? MEM_COST : miss_cost + MEM_COST;
        end else begin
            cost = MEM_COST;
        end
        if (wb) begin
            cost = cost + miss_cost;
        end
    end

    // result register
    logic r_out_valid;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out.hit         <= r_hit;
            r_out.wrote_back  <= wb;
            r_out.cost_cycles <= cost;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

endmodule

// ----- src/salc_checker.sv -----
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks on the cache tag controller, bound to the top level.
// ----------------------------------------------------------------------------
module salc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input salc_pkg::t_out_item o_out_data
);
    import salc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transfer taken during an access");

    a_wb_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.wrote_back |-> !o_out_data.hit)
        else $error("write-back reported on a hit");

    a_hit_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.hit |->
            (o_out_data.cost_cycles == HIT_COST || o_out_data.cost_cycles == MEM_COST))
        else $error("bad hit cost");

endmodule

bind set_assoc_cache_lru_tag_controller_top salc_checker u_salc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
